// ===== src/im2c_pkg.sv =====
// ----------------------------------------------------------------------------
// im2c_pkg
// Shared widths, register codes and interface structs of the im2col
// patch address generator.
// ----------------------------------------------------------------------------
package im2c_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int MAX_CHAN   = 1024;
    localparam int MAX_KERNEL = 15;

    localparam int DIM_W      = 11;   // map sizes and channel count registers
    localparam int CHAN_W     = 10;   // channel counter
    localparam int KER_W      = 4;    // kernel size, stride, padding
    localparam int SPAN_W     = 12;   // padded size minus kernel
    localparam int PROW_W     = 18;
    localparam int PCOL_W     = 21;
    localparam int COORD_W    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int S_TDATA_W  = 8;
    localparam int M_FIELDS_W = PROW_W + PCOL_W + CHAN_W + 2 * COORD_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT   = 3'd0,
        REG_IN_WIDTH    = 3'd1,
        REG_IN_CHANNELS = 3'd2,
        REG_KERNEL_ROWS = 3'd3,
        REG_KERNEL_COLS = 3'd4,
        REG_STEP_SIZE   = 3'd5,
        REG_PAD_AMOUNT  = 3'd6
    } cfg_reg_t;

    // decoded, saturated configuration
    typedef struct packed {
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  channels;
        logic [KER_W-1:0]  krows;
        logic [KER_W-1:0]  kcols;
        logic [KER_W-1:0]  stride;
        logic [KER_W-1:0]  pad;
        logic [SPAN_W-1:0] span_r;
        logic [SPAN_W-1:0] span_c;
        logic              empty;
    } cfg_t;

    // walk position held in the first stage
    typedef struct packed {
        logic              empty;
        logic [CHAN_W-1:0] chan;
        logic [KER_W-1:0]  krow;
        logic [KER_W-1:0]  kcol;
        logic [DIM_W-1:0]  row_base;
        logic [DIM_W-1:0]  col_base;
        logic [PROW_W-1:0] prow;
        logic [PCOL_W-1:0] pcol;
    } walk_t;

endpackage

// ===== src/im2c_cfg.sv =====
// ----------------------------------------------------------------------------
// im2c_cfg
// Configuration registers with saturation, stride fix-up and the output
// extent spans used by the walker.
// ----------------------------------------------------------------------------
module im2c_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2c_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           cfg_wr,
    output im2c_pkg::cfg_t                 cfg
);
    import im2c_pkg::*;

    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] chans_reg, chans_next;
    logic [KER_W-1:0] krows_reg, krows_next;
    logic [KER_W-1:0] kcols_reg, kcols_next;
    logic [KER_W-1:0] stride_reg, stride_next;
    logic [KER_W-1:0] pad_reg, pad_next;
    logic [SPAN_W-1:0] padded_h, padded_w;

    assign cfg_ready = 1'b1;

    always_comb begin
        height_next = height_reg;
        width_next  = width_reg;
        chans_next  = chans_reg;
        krows_next  = krows_reg;
        kcols_next  = kcols_reg;
        stride_next = stride_reg;
        pad_next    = pad_reg;
        cfg_wr      = 1'b0;
        if (cfg_valid) begin
            cfg_wr = 1'b1;
            unique case (cfg_index)
                REG_IN_HEIGHT:   height_next = cfg_data;
                REG_IN_WIDTH:    width_next  = cfg_data;
                REG_IN_CHANNELS: chans_next  = cfg_data;
                REG_KERNEL_ROWS: krows_next  = cfg_data[KER_W-1:0];
                REG_KERNEL_COLS: kcols_next  = cfg_data[KER_W-1:0];
                REG_STEP_SIZE:   stride_next = cfg_data[KER_W-1:0];
                REG_PAD_AMOUNT:  pad_next    = cfg_data[KER_W-1:0];
                default:         cfg_wr      = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= DIM_W'(1);
            width_reg  <= DIM_W'(1);
            chans_reg  <= DIM_W'(1);
            krows_reg  <= KER_W'(1);
            kcols_reg  <= KER_W'(1);
            stride_reg <= KER_W'(1);
            pad_reg    <= '0;
        end else begin
            height_reg <= height_next;
            width_reg  <= width_next;
            chans_reg  <= chans_next;
            krows_reg  <= krows_next;
            kcols_reg  <= kcols_next;
            stride_reg <= stride_next;
            pad_reg    <= pad_next;
        end
    end

    // kernel registers cannot exceed the kernel limit, so they pass as they are
    always_comb begin
        cfg.height   = (height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_reg;
        cfg.width    = (width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_reg;
        cfg.channels = (chans_reg > DIM_W'(MAX_CHAN)) ? DIM_W'(MAX_CHAN) : chans_reg;
        cfg.krows    = krows_reg;
        cfg.kcols    = kcols_reg;
        cfg.stride   = (stride_reg == '0) ? KER_W'(1) : stride_reg;
        cfg.pad      = pad_reg;
        padded_h     = SPAN_W'(cfg.height) + SPAN_W'({pad_reg, 1'b0});
        padded_w     = SPAN_W'(cfg.width) + SPAN_W'({pad_reg, 1'b0});
        cfg.span_r   = padded_h - SPAN_W'(krows_reg);
        cfg.span_c   = padded_w - SPAN_W'(kcols_reg);
        cfg.empty    = (cfg.height == '0) || (cfg.width == '0) || (cfg.channels == '0) ||
                       (krows_reg == '0) || (kcols_reg == '0) ||
                       (padded_h < SPAN_W'(krows_reg)) || (padded_w < SPAN_W'(kcols_reg));
    end

endmodule

// ===== src/im2c_walk.sv =====
// ----------------------------------------------------------------------------
// im2c_walk
// Loop-nest counters of the walk; advances one position per request and
// holds the position as the first pipeline stage.
// ----------------------------------------------------------------------------
module im2c_walk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  im2c_pkg::cfg_t                cfg,
    input  logic                          cfg_wr,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [im2c_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          down_ready,
    output logic                          walk_valid,
    output im2c_pkg::walk_t               walk
);
    import im2c_pkg::*;

    logic              started_reg, started_next;
    logic              valid_reg, valid_next;
    logic              empty_reg, empty_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [KER_W-1:0]  krow_reg, krow_next;
    logic [KER_W-1:0]  kcol_reg, kcol_next;
    logic [DIM_W-1:0]  row_base_reg, row_base_next;
    logic [DIM_W-1:0]  col_base_reg, col_base_next;
    logic [PROW_W-1:0] prow_reg, prow_next;
    logic [PCOL_W-1:0] pcol_reg, pcol_next;

    logic              accept;
    logic [SPAN_W-1:0] col_step, row_step;
    logic              col_adv, row_adv, kcol_adv, krow_adv, chan_adv;

    assign s_tready = !valid_reg || down_ready;
    assign accept   = s_tvalid && s_tready;

    assign col_step = SPAN_W'(col_base_reg) + SPAN_W'(cfg.stride);
    assign row_step = SPAN_W'(row_base_reg) + SPAN_W'(cfg.stride);
    assign col_adv  = col_step <= cfg.span_c;
    assign row_adv  = row_step <= cfg.span_r;
    assign kcol_adv = (5'(kcol_reg) + 5'd1) < 5'(cfg.kcols);
    assign krow_adv = (5'(krow_reg) + 5'd1) < 5'(cfg.krows);
    assign chan_adv = (DIM_W'(chan_reg) + DIM_W'(1)) < cfg.channels;

    always_comb begin
        started_next  = started_reg;
        chan_next     = chan_reg;
        krow_next     = krow_reg;
        kcol_next     = kcol_reg;
        row_base_next = row_base_reg;
        col_base_next = col_base_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        empty_next    = empty_reg;
        valid_next    = valid_reg && !down_ready;

        if (accept) begin
            valid_next = 1'b1;
            empty_next = cfg.empty;
            // an empty walk leaves the position where it is
            if (!cfg.empty) begin
                priority if (s_tdata[0] || !started_reg) begin
                    started_next  = 1'b1;
                    chan_next     = '0;
                    krow_next     = '0;
                    kcol_next     = '0;
                    row_base_next = '0;
                    col_base_next = '0;
                    prow_next     = '0;
                    pcol_next     = '0;
                end else if (col_adv) begin
                    col_base_next = col_step[DIM_W-1:0];
                    pcol_next     = pcol_reg + PCOL_W'(1);
                end else if (row_adv) begin
                    col_base_next = '0;
                    row_base_next = row_step[DIM_W-1:0];
                    pcol_next     = pcol_reg + PCOL_W'(1);
                end else begin
                    // output grid done: next kernel tap
                    col_base_next = '0;
                    row_base_next = '0;
                    pcol_next     = '0;
                    prow_next     = prow_reg + PROW_W'(1);
                    priority if (kcol_adv) begin
                        kcol_next = kcol_reg + KER_W'(1);
                    end else if (krow_adv) begin
                        kcol_next = '0;
                        krow_next = krow_reg + KER_W'(1);
                    end else if (chan_adv) begin
                        kcol_next = '0;
                        krow_next = '0;
                        chan_next = chan_reg + CHAN_W'(1);
                    end else begin
                        kcol_next = '0;
                        krow_next = '0;
                        chan_next = '0;
                        prow_next = '0;
                    end
                end
            end
        end

        if (cfg_wr) begin
            started_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            valid_reg    <= 1'b0;
            empty_reg    <= 1'b0;
            chan_reg     <= '0;
            krow_reg     <= '0;
            kcol_reg     <= '0;
            row_base_reg <= '0;
            col_base_reg <= '0;
            prow_reg     <= '0;
            pcol_reg     <= '0;
        end else begin
            started_reg  <= started_next;
            valid_reg    <= valid_next;
            empty_reg    <= empty_next;
            chan_reg     <= chan_next;
            krow_reg     <= krow_next;
            kcol_reg     <= kcol_next;
            row_base_reg <= row_base_next;
            col_base_reg <= col_base_next;
            prow_reg     <= prow_next;
            pcol_reg     <= pcol_next;
        end
    end

    assign walk_valid    = valid_reg;
    assign walk.empty    = empty_reg;
    assign walk.chan     = chan_reg;
    assign walk.krow     = krow_reg;
    assign walk.kcol     = kcol_reg;
    assign walk.row_base = row_base_reg;
    assign walk.col_base = col_base_reg;
    assign walk.prow     = prow_reg;
    assign walk.pcol     = pcol_reg;

endmodule

// ===== src/im2c_out.sv =====
// ----------------------------------------------------------------------------
// im2c_out
// Source coordinates, padding and last flags from the walk position, held
// in the result register.
// ----------------------------------------------------------------------------
module im2c_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  im2c_pkg::cfg_t                cfg,
    input  logic                          walk_valid,
    input  im2c_pkg::walk_t               walk,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [im2c_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser
);
    import im2c_pkg::*;

    logic                  valid_reg, valid_next;
    logic [M_TDATA_W-1:0]  data_reg, data_next;
    logic                  last_reg, last_next;
    logic                  nop_reg, nop_next;

    logic [COORD_W-1:0]    src_row, src_col;
    logic                  pad_flag, last_flag;

    assign take = !valid_reg || m_tready;

    always_comb begin
        src_row = COORD_W'(walk.row_base) + COORD_W'(walk.krow) - COORD_W'(cfg.pad);
        src_col = COORD_W'(walk.col_base) + COORD_W'(walk.kcol) - COORD_W'(cfg.pad);
        // negative shows in the sign bit, otherwise compare against the map size
        pad_flag = src_row[COORD_W-1] || (src_row >= COORD_W'(cfg.height)) ||
                   src_col[COORD_W-1] || (src_col >= COORD_W'(cfg.width));
        last_flag = ((DIM_W'(walk.chan) + DIM_W'(1)) == cfg.channels) &&
                    ((5'(walk.krow) + 5'd1) == 5'(cfg.krows)) &&
                    ((5'(walk.kcol) + 5'd1) == 5'(cfg.kcols)) &&
                    ((SPAN_W'(walk.row_base) + SPAN_W'(cfg.stride)) > cfg.span_r) &&
                    ((SPAN_W'(walk.col_base) + SPAN_W'(cfg.stride)) > cfg.span_c);

        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        nop_next   = nop_reg;
        if (walk_valid && take) begin
            valid_next = 1'b1;
            if (walk.empty) begin
                data_next = '0;
                last_next = 1'b0;
                nop_next  = 1'b1;
            end else begin
                data_next = M_TDATA_W'({pad_flag, src_col, src_row, walk.chan,
                                        walk.pcol, walk.prow});
                last_next = last_flag;
                nop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        nop_reg  <= nop_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tlast    = last_reg;
    assign m_tuser[0] = nop_reg;

endmodule

// ===== src/im2col_address_generator.sv =====
// ----------------------------------------------------------------------------
// im2col_address_generator
// Walks the im2col loop nest and issues one patch element address per request.
// ----------------------------------------------------------------------------
// Each request on the s_ channel (restart flag in s_tdata bit 0) yields one
// result on the m_ channel: patch matrix row and column, source channel,
// signed source row and column, and a padding flag in m_tdata; m_tlast marks
// the final position of the walk and m_tuser flags an empty walk (a zero
// size or a kernel larger than the padded map), with every other field zero.
// The walk order, outermost first, is channel, kernel row, kernel column,
// output row, output column, and it wraps after the last position.
// The cfg channel writes one register per request (index 0..6: height,
// width, channels, kernel rows, kernel columns, stride, padding); it is
// always ready. The user must see that it is used only while no request
// is in flight; the block itself does not enforce this. A write makes
// the next request start at the first position. One request per cycle is
// taken while the receiver keeps up; the walk counters form the first
// stage, the result register the second. Reset restores the default
// configuration and restarts the walk. When the receiver stalls, the
// result holds, the walk stage keeps one more request, then s_tready drops.
// ----------------------------------------------------------------------------
module im2col_address_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [im2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2c_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [im2c_pkg::S_TDATA_W-1:0]  s_tdata,   // restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // patch_row, patch_col, src_channel, src_row, src_col, is_padding
    output logic [im2c_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic [0:0]                     m_tuser    // no_patches
);
    import im2c_pkg::*;

    cfg_t  cfg;
    walk_t walk;
    logic  cfg_wr;
    logic  walk_valid;
    logic  take;

    im2c_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_wr    (cfg_wr),
        .cfg       (cfg)
    );

    im2c_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_wr     (cfg_wr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .down_ready (take),
        .walk_valid (walk_valid),
        .walk       (walk)
    );

    im2c_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .walk_valid (walk_valid),
        .walk       (walk),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
